// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/wes_pkg.sv =====
package wes_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [10:0] MINUTE_MAX = 11'd1439;
	localparam logic [12:0] MINUTES_PER_DAY = 13'd1440;
	localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

	// Multiple of seven days that makes any local time non-negative.
	localparam logic [33:0] TIME_BIAS = 34'd2147644800;

	// Seconds per day is 128 * 675. For n below 2**26, n / 675 is (n * DAY_RECIP) >> 36;
	// for s below 2**17, s / 60 is (s * MIN_RECIP) >> 23.
	localparam logic [26:0] DAY_DIV = 27'd675;
	localparam logic [26:0] DAY_RECIP = 27'd101806633;
	localparam logic [26:0] MIN_RECIP = 27'd139811;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_QUERY = 2'd2,
		FN_QUERY_NEXT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	localparam logic REG_TIMEZONE = 1'b0;
	localparam logic REG_EPOCH_DAY = 1'b1;

	typedef struct packed {
		logic [2:0] day;
		logic [10:0] minute;
		logic [2:0] active_day;
		logic [10:0] active_minute;
		logic [7:0] tag;
	} entry_t;

endpackage

// ===== hw/rtl/weekly_event_schedule_table.sv =====
// Channel    Handshake          Payload
// command    start / busy       func, week_day, minute_offset, random_minutes, tag, timestamp
// result     done (one cycle)   status, hit_*, entry_count
// config     cfg_we             cfg_index, cfg_wdata
//
// Insert and remove are paced by the single table port that walks and shifts one entry a
// cycle. A query uses the shared multiplier for day, weekday and minute in turn, then scans
// the table for the hit and reads it. A full insert, or a query or remove on an empty table,
// answers straight from the idle state. Reset empties the table at once. Results cannot be
// stalled; a new transfer is taken in the cycle done is high.
`include "assert_macros.svh"

module weekly_event_schedule_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [16:0] cfg_wdata,
	input logic [1:0] func,
	input logic [2:0] week_day,
	input logic [10:0] minute_offset,
	input logic signed [10:0] random_minutes,
	input logic [7:0] tag,
	input logic signed [31:0] timestamp,
	output logic [1:0] status,
	output logic hit_valid,
	output logic [wes_pkg::IDX_W-1:0] hit_index,
	output logic [2:0] hit_week_day,
	output logic [10:0] hit_minute,
	output logic [2:0] hit_active_day,
	output logic [10:0] hit_active_minute,
	output logic [7:0] hit_tag,
	output logic [wes_pkg::CNT_W-1:0] entry_count
);

	localparam int IW = wes_pkg::IDX_W;
	localparam int CW = wes_pkg::CNT_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_INS = 9'b000000010,
		S_REM_FIND = 9'b000000100,
		S_REM_SHIFT = 9'b000001000,
		S_DIV_DAY = 9'b000010000,
		S_DIV_WEEK = 9'b000100000,
		S_DIV_MIN = 9'b001000000,
		S_SCAN = 9'b010000000,
		S_HIT = 9'b100000000
	} state_t;

	state_t state_q;
	wes_pkg::entry_t mem_q [wes_pkg::TABLE_DEPTH];
	wes_pkg::entry_t new_q;
	wes_pkg::entry_t new_d;
	wes_pkg::entry_t rd_data;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [1:0] func_q;
	logic signed [16:0] tz_q;
	logic [2:0] epoch_q;
	logic [25:0] num_q;
	logic [6:0] low_q;
	logic [16:0] days_q;
	logic [16:0] sec_q;
	logic [2:0] wd_q;
	logic [10:0] qmin_q;
	logic done_q;
	logic [1:0] status_q;
	logic hit_valid_q;
	logic [IW-1:0] hit_index_q;
	wes_pkg::entry_t hit_q;
	logic [CW-1:0] entry_count_q;

	logic mem_we;
	logic [IW-1:0] mem_waddr;
	wes_pkg::entry_t mem_wdata;

	logic [26:0] mul_a;
	logic [26:0] mul_b;
	logic [53:0] prod;
	logic [25:0] day_rem;

	logic [2:0] day_n;
	logic [10:0] min_n;
	logic signed [12:0] sum_min;
	logic signed [33:0] local_b;
	logic [5:0] oct_sum;
	logic [3:0] oct_fold;
	logic [4:0] week_sum;
	logic [2:0] week_mod;
	logic key_gt;
	logic key_le;
	logic key_match;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] scan_hit;
	logic [IW-1:0] next_hit;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign hit_valid = hit_valid_q;
	assign hit_index = hit_index_q;
	assign hit_week_day = hit_q.day;
	assign hit_minute = hit_q.minute;
	assign hit_active_day = hit_q.active_day;
	assign hit_active_minute = hit_q.active_minute;
	assign hit_tag = hit_q.tag;
	assign entry_count = entry_count_q;

	// The new entry with normalized nominal fields and the active time after the offset.
	always_comb begin
		day_n = (week_day == 3'd0) ? wes_pkg::DAYS_PER_WEEK : week_day;
		min_n = (minute_offset > wes_pkg::MINUTE_MAX) ? wes_pkg::MINUTE_MAX : minute_offset;
		sum_min = $signed({2'b00, min_n}) + 13'(random_minutes);
		new_d.day = day_n;
		new_d.minute = min_n;
		new_d.tag = tag;
		if (sum_min < 0) begin
			new_d.active_minute = 11'(sum_min + $signed(wes_pkg::MINUTES_PER_DAY));
			new_d.active_day = (day_n == 3'd1) ? wes_pkg::DAYS_PER_WEEK : day_n - 3'd1;
		end else if (sum_min >= $signed(wes_pkg::MINUTES_PER_DAY)) begin
			new_d.active_minute = 11'(sum_min - $signed(wes_pkg::MINUTES_PER_DAY));
			new_d.active_day = (day_n == wes_pkg::DAYS_PER_WEEK) ? 3'd1 : day_n + 3'd1;
		end else begin
			new_d.active_minute = 11'(sum_min);
			new_d.active_day = day_n;
		end
		local_b = 34'(timestamp) + 34'(tz_q) + $signed(wes_pkg::TIME_BIAS);
	end

	always_comb begin
		case (state_q)
			S_INS: rd_addr = idx_q - 1'b1;
			S_REM_SHIFT: rd_addr = idx_q + 1'b1;
			default: rd_addr = idx_q;
		endcase
		rd_data = mem_q[rd_addr];
	end

	// Shared multiplier: day quotient, day remainder, then minute of day.
	always_comb begin
		case (state_q)
			S_DIV_DAY: begin
				mul_a = {1'b0, num_q};
				mul_b = wes_pkg::DAY_RECIP;
			end
			S_DIV_WEEK: begin
				mul_a = {10'd0, days_q};
				mul_b = wes_pkg::DAY_DIV;
			end
			default: begin
				mul_a = {10'd0, sec_q};
				mul_b = wes_pkg::MIN_RECIP;
			end
		endcase
		prod = {27'd0, mul_a} * {27'd0, mul_b};
		day_rem = num_q - prod[25:0];
	end

	// Eight is one modulo seven, so the octal digits of the day count sum to its weekday.
	always_comb begin
		oct_sum = 6'(days_q[2:0]) + 6'(days_q[5:3]) + 6'(days_q[8:6]) + 6'(days_q[11:9])
			+ 6'(days_q[14:12]) + 6'(days_q[16:15]);
		oct_fold = {1'b0, oct_sum[5:3]} + {1'b0, oct_sum[2:0]};
		week_sum = {1'b0, oct_fold} + {2'b00, epoch_q};
		if (week_sum >= 5'd14) begin
			week_mod = 3'(week_sum - 5'd14);
		end else if (week_sum >= 5'd7) begin
			week_mod = 3'(week_sum - 5'd7);
		end else begin
			week_mod = week_sum[2:0];
		end
	end

	always_comb begin
		key_gt = (rd_data.active_day > new_q.active_day)
			|| (rd_data.active_day == new_q.active_day
			&& rd_data.active_minute > new_q.active_minute);
		key_le = (rd_data.active_day < wd_q)
			|| (rd_data.active_day == wd_q && rd_data.active_minute <= qmin_q);
		key_match = (rd_data.day == new_q.day) && (rd_data.minute == new_q.minute)
			&& (rd_data.tag == new_q.tag);
		last_idx = IW'(count_q - 1'b1);
		scan_hit = key_le ? idx_q : last_idx;
		next_hit = (CW'(scan_hit) + 1'b1 == count_q) ? '0 : scan_hit + 1'b1;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_data;
		case (state_q)
			S_INS: begin
				mem_we = 1'b1;
				if (idx_q == '0 || !key_gt) begin
					mem_wdata = new_q;
				end
			end
			S_REM_SHIFT: begin
				mem_we = (CW'(idx_q) + 1'b1 < count_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= '0;
			epoch_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				wes_pkg::REG_TIMEZONE: tz_q <= $signed(cfg_wdata);
				wes_pkg::REG_EPOCH_DAY: epoch_q <= cfg_wdata[2:0];
				default: tz_q <= tz_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				new_q <= new_d;
				func_q <= func;
				num_q <= local_b[32:7];
				low_q <= local_b[6:0];
			end
			S_DIV_DAY: begin
				days_q <= prod[52:36];
			end
			S_DIV_WEEK: begin
				sec_q <= {day_rem[9:0], low_q};
				wd_q <= (week_mod == 3'd0) ? wes_pkg::DAYS_PER_WEEK : week_mod;
			end
			S_DIV_MIN: begin
				qmin_q <= prod[33:23];
			end
			default: begin
				days_q <= days_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			count_q <= '0;
			done_q <= 1'b0;
			status_q <= wes_pkg::ST_OK;
			hit_valid_q <= 1'b0;
			hit_index_q <= '0;
			hit_q <= '0;
			entry_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						hit_valid_q <= 1'b0;
						hit_index_q <= '0;
						hit_q <= '0;
						entry_count_q <= count_q;
						case (func)
							wes_pkg::FN_INSERT: begin
								if (count_q == CW'(wes_pkg::TABLE_DEPTH)) begin
									done_q <= 1'b1;
									status_q <= wes_pkg::ST_FULL;
								end else begin
									idx_q <= IW'(count_q);
									state_q <= S_INS;
								end
							end
							wes_pkg::FN_REMOVE: begin
								idx_q <= '0;
								if (count_q == '0) begin
									done_q <= 1'b1;
									status_q <= wes_pkg::ST_NOT_FOUND;
								end else begin
									state_q <= S_REM_FIND;
								end
							end
							default: begin
								idx_q <= '0;
								if (count_q == '0) begin
									done_q <= 1'b1;
									status_q <= wes_pkg::ST_EMPTY;
								end else begin
									state_q <= S_DIV_DAY;
								end
							end
						endcase
					end
				end
				S_INS: begin
					if (idx_q != '0 && key_gt) begin
						idx_q <= idx_q - 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						entry_count_q <= count_q + 1'b1;
						status_q <= wes_pkg::ST_OK;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_REM_FIND: begin
					if (key_match) begin
						state_q <= S_REM_SHIFT;
					end else if (idx_q == last_idx) begin
						status_q <= wes_pkg::ST_NOT_FOUND;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REM_SHIFT: begin
					if (CW'(idx_q) + 1'b1 < count_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						entry_count_q <= count_q - 1'b1;
						status_q <= wes_pkg::ST_OK;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV_DAY: begin
					state_q <= S_DIV_WEEK;
				end
				S_DIV_WEEK: begin
					state_q <= S_DIV_MIN;
				end
				S_DIV_MIN: begin
					idx_q <= last_idx;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (key_le || idx_q == '0) begin
						idx_q <= (func_q == wes_pkg::FN_QUERY_NEXT) ? next_hit : scan_hit;
						state_q <= S_HIT;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_HIT: begin
					hit_valid_q <= 1'b1;
					hit_index_q <= idx_q;
					hit_q <= rd_data;
					status_q <= wes_pkg::ST_OK;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_range, count_q <= CW'(wes_pkg::TABLE_DEPTH), "entry count overflow")
	`ASSERT_IMPLIES(a_done_idle, done_q, state_q == S_IDLE, "result transfer while busy")
	`ASSERT_IMPLIES(a_hit_in_table, hit_valid_q, CW'(hit_index_q) < entry_count_q && status_q == wes_pkg::ST_OK, "hit outside table")
	`ASSERT_IMPLIES(a_count_on_done, count_q != $past(count_q), done_q && entry_count_q == count_q, "count changed without result")

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wes_pkg::*;

	localparam int RUN_LIMIT = 500000;
	localparam int PHASES = 8;
	localparam int PHASE_CMDS = 125;

	typedef struct packed {
		func_t fn;
		logic [2:0] wd;
		logic [10:0] mo;
		logic signed [10:0] rnd;
		logic [7:0] tg;
		logic signed [31:0] ts;
	} cmd_t;

	typedef struct packed {
		logic [1:0] st;
		logic hv;
		logic [IDX_W-1:0] idx;
		logic [2:0] wd;
		logic [10:0] mn;
		logic [2:0] ad;
		logic [10:0] am;
		logic [7:0] tg;
		logic [CNT_W-1:0] cnt;
	} outcome_t;

	typedef enum {JOB_CMD, JOB_REG, JOB_PACE} job_kind_t;

	typedef struct {
		job_kind_t kind;
		cmd_t cmd;
		logic [0:0] reg_idx;
		logic [16:0] reg_data;
		int pace;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_TIMEZONE;
	logic [16:0] cfg_wdata = '0;
	logic [1:0] func = FN_INSERT;
	logic [2:0] week_day = '0;
	logic [10:0] minute_offset = '0;
	logic signed [10:0] random_minutes = '0;
	logic [7:0] tag = '0;
	logic signed [31:0] timestamp = '0;
	logic [1:0] status;
	logic hit_valid;
	logic [IDX_W-1:0] hit_index;
	logic [2:0] hit_week_day;
	logic [10:0] hit_minute;
	logic [2:0] hit_active_day;
	logic [10:0] hit_active_minute;
	logic [7:0] hit_tag;
	logic [CNT_W-1:0] entry_count;

	weekly_event_schedule_table uut (.*);

	always #1 clk = ~clk;

	// Predicted block state.
	entry_t sched[TABLE_DEPTH];
	int stored = 0;
	logic signed [16:0] tz_now = '0;
	logic [2:0] epoch_now = 3'd4;

	job_t backlog[$];
	outcome_t predicted_replies[$];
	logic [21:0] held_keys[$];
	cmd_t live_cmd;
	int idle_pct = 0;
	int faults = 0;
	int cycles = 0;
	bit filling = 1'b1;

	function automatic logic [2:0] fold_day(input logic [2:0] d);
		return (d == 3'd0) ? 3'd7 : d;
	endfunction

	function automatic logic [10:0] clip_minute(input logic [10:0] m);
		return (m > MINUTE_MAX) ? MINUTE_MAX : m;
	endfunction

	function automatic string fmt_outcome(input outcome_t o);
		return $sformatf("st=%0d hv=%0d idx=%0d day=%0d min=%0d aday=%0d amin=%0d tag=%0d cnt=%0d",
			o.st, o.hv, o.idx, o.wd, o.mn, o.ad, o.am, o.tg, o.cnt);
	endfunction

	function automatic void schedule_step(input cmd_t c, output outcome_t o);
		entry_t fresh;
		int s, r, pos, hit;
		longint loc, days, rem, wkd, ep;
		logic [2:0] d, now_day;
		logic [10:0] m, now_min;
		o = '0;
		d = fold_day(c.wd);
		m = clip_minute(c.mo);
		case (c.fn)
			FN_INSERT: begin
				if (stored >= TABLE_DEPTH) begin
					o.st = ST_FULL;
				end else begin
					r = c.rnd;
					s = int'(m) + r;
					fresh.day = d;
					fresh.minute = m;
					fresh.tag = c.tg;
					if (s < 0) begin
						fresh.active_minute = 11'(s + 1440);
						fresh.active_day = 3'((d + 5) % 7 + 1);
					end else if (s >= 1440) begin
						fresh.active_minute = 11'(s - 1440);
						fresh.active_day = 3'(d % 7 + 1);
					end else begin
						fresh.active_minute = 11'(s);
						fresh.active_day = d;
					end
					pos = stored;
					for (int i = 0; i < stored; i++) begin
						if ({sched[i].active_day, sched[i].active_minute} >
							{fresh.active_day, fresh.active_minute}) begin
							pos = i;
							break;
						end
					end
					for (int i = stored; i > pos; i--)
						sched[i] = sched[i - 1];
					sched[pos] = fresh;
					stored++;
				end
			end
			FN_REMOVE: begin
				hit = -1;
				for (int i = 0; i < stored; i++) begin
					if (sched[i].day == d && sched[i].minute == m && sched[i].tag == c.tg) begin
						hit = i;
						break;
					end
				end
				if (hit < 0) begin
					o.st = ST_NOT_FOUND;
				end else begin
					for (int i = hit; i + 1 < stored; i++)
						sched[i] = sched[i + 1];
					stored--;
				end
			end
			default: begin
				if (stored == 0) begin
					o.st = ST_EMPTY;
				end else begin
					if (stored == 1) begin
						hit = 0;
					end else begin
						loc = c.ts;
						loc += tz_now;
						days = loc / 86400;
						rem = loc % 86400;
						if (rem < 0) begin
							rem += 86400;
							days -= 1;
						end
						ep = epoch_now;
						wkd = (days % 7 + 7 + ep) % 7;
						if (wkd == 0)
							wkd = 7;
						now_day = 3'(wkd);
						now_min = 11'(rem / 60);
						hit = stored - 1;
						for (int i = stored - 1; i >= 0; i--) begin
							if (sched[i].active_day < now_day || (sched[i].active_day == now_day &&
								sched[i].active_minute <= now_min)) begin
								hit = i;
								break;
							end
						end
					end
					if (c.fn == FN_QUERY_NEXT)
						hit = (hit + 1) % stored;
					o.hv = 1'b1;
					o.idx = IDX_W'(hit);
					o.wd = sched[hit].day;
					o.mn = sched[hit].minute;
					o.ad = sched[hit].active_day;
					o.am = sched[hit].active_minute;
					o.tg = sched[hit].tag;
				end
			end
		endcase
		o.cnt = CNT_W'(stored);
	endfunction

	task automatic push_cmd(input func_t fn, input logic [2:0] wd, input logic [10:0] mo,
		input logic signed [10:0] rnd, input logic [7:0] tg, input logic signed [31:0] ts);
		job_t j;
		logic [21:0] key;
		key = {fold_day(wd), clip_minute(mo), tg};
		if (fn == FN_INSERT && held_keys.size() < TABLE_DEPTH)
			held_keys.push_back(key);
		if (fn == FN_REMOVE) begin
			for (int i = 0; i < held_keys.size(); i++) begin
				if (held_keys[i] == key) begin
					held_keys.delete(i);
					break;
				end
			end
		end
		j.kind = JOB_CMD;
		j.cmd.fn = fn;
		j.cmd.wd = wd;
		j.cmd.mo = mo;
		j.cmd.rnd = rnd;
		j.cmd.tg = tg;
		j.cmd.ts = ts;
		j.reg_idx = REG_TIMEZONE;
		j.reg_data = '0;
		j.pace = 0;
		backlog.push_back(j);
	endtask

	task automatic push_job(input job_kind_t kind, input logic [0:0] idx, input logic [16:0] data,
		input int pace);
		job_t j;
		j.kind = kind;
		j.cmd = '0;
		j.reg_idx = idx;
		j.reg_data = data;
		j.pace = pace;
		backlog.push_back(j);
	endtask

	task automatic add_random_cmd();
		func_t fn;
		logic [2:0] wd;
		logic [10:0] mo;
		logic signed [10:0] rnd;
		logic [7:0] tg;
		logic signed [31:0] ts;
		logic [21:0] key;
		int roll;
		wd = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 9))
			0: mo = 11'($urandom_range(1440, 2047));
			1, 2: mo = ($urandom_range(0, 1) == 0) ? 11'd0 : MINUTE_MAX;
			default: mo = 11'($urandom_range(0, 1439));
		endcase
		rnd = ($urandom_range(0, 4) == 0) ? 11'sd0 : 11'($urandom);
		tg = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		case ($urandom_range(0, 19))
			0: ts = 32'h8000_0000;
			1: ts = 32'h7FFF_FFFF;
			2: ts = 32'hFFFF_FFFF;
			default: ts = 32'($urandom);
		endcase
		roll = $urandom_range(0, 99);
		if (roll < (filling ? 55 : 15))
			fn = FN_INSERT;
		else if (roll < 70)
			fn = FN_REMOVE;
		else if (roll < 85)
			fn = FN_QUERY;
		else
			fn = FN_QUERY_NEXT;
		if (fn == FN_REMOVE && held_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
			key = held_keys[$urandom_range(0, held_keys.size() - 1)];
			wd = key[21:19];
			mo = key[18:8];
			tg = key[7:0];
			if (wd == 3'd7 && $urandom_range(0, 1) == 0)
				wd = 3'd0;
			if (mo == MINUTE_MAX && $urandom_range(0, 1) == 0)
				mo = 11'($urandom_range(1440, 2047));
		end
		push_cmd(fn, wd, mo, rnd, tg, ts);
		if (held_keys.size() == TABLE_DEPTH && $urandom_range(0, 3) == 0)
			filling = 1'b0;
		else if (held_keys.size() == 0)
			filling = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_proc
		job_t nxt;
		outcome_t o;
		bit took, hold, go, wr;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
		end else begin
			took = start && !busy;
			if (took) begin
				schedule_step(live_cmd, o);
				predicted_replies.push_back(o);
			end
			hold = start && !took;
			go = 1'b0;
			wr = 1'b0;
			if (!hold && backlog.size() > 0) begin
				nxt = backlog[0];
				case (nxt.kind)
					JOB_PACE: begin
						idle_pct = nxt.pace;
						void'(backlog.pop_front());
					end
					JOB_REG: begin
						if (!took && !busy && !done && predicted_replies.size() == 0) begin
							cfg_index <= nxt.reg_idx;
							cfg_wdata <= nxt.reg_data;
							wr = 1'b1;
							if (nxt.reg_idx == REG_TIMEZONE)
								tz_now = nxt.reg_data;
							else
								epoch_now = nxt.reg_data[2:0];
							void'(backlog.pop_front());
						end
					end
					default: begin
						if ($urandom_range(0, 99) >= idle_pct) begin
							func <= nxt.cmd.fn;
							week_day <= nxt.cmd.wd;
							minute_offset <= nxt.cmd.mo;
							random_minutes <= nxt.cmd.rnd;
							tag <= nxt.cmd.tg;
							timestamp <= nxt.cmd.ts;
							live_cmd = nxt.cmd;
							go = 1'b1;
							void'(backlog.pop_front());
						end
					end
				endcase
			end
			cfg_we <= wr;
			if (!hold)
				start <= go;
		end
	end

	always @(posedge clk) begin : check_proc
		outcome_t got, want;
		if (arst_n && done) begin
			got.st = status;
			got.hv = hit_valid;
			got.idx = hit_index;
			got.wd = hit_week_day;
			got.mn = hit_minute;
			got.ad = hit_active_day;
			got.am = hit_active_minute;
			got.tg = hit_tag;
			got.cnt = entry_count;
			if (predicted_replies.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: %s", fmt_outcome(got));
			end else begin
				want = predicted_replies.pop_front();
				if (got !== want) begin
					faults++;
					if (faults <= 10)
						$display("mismatch: expected %s\n          actual   %s",
							fmt_outcome(want), fmt_outcome(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == RUN_LIMIT) begin
			$display("[weekly_event_schedule_table] ERROR");
			$finish;
		end
	end

	initial begin : stim_proc
		logic [16:0] tz_plan[4];
		logic [2:0] ep_plan[4];
		int pace_plan[4];
		logic [16:0] tzv;
		logic [2:0] epv;
		tz_plan = '{17'(-50400), 17'(50400), 17'h1_0000, 17'h0_FFFF};
		ep_plan = '{3'd1, 3'd7, 3'd0, 3'd3};
		pace_plan = '{0, 67, 0, 34};

		// Empty table, then a single entry, then sorting with wraps and equal keys.
		push_cmd(FN_QUERY, 3'd1, 11'd0, 11'sd0, 8'd0, 32'sd0);
		push_cmd(FN_QUERY_NEXT, 3'd1, 11'd0, 11'sd0, 8'd0, 32'sd0);
		push_cmd(FN_REMOVE, 3'd7, 11'd1439, 11'sd0, 8'd0, 32'sd0);
		push_cmd(FN_INSERT, 3'd0, 11'd2047, 11'h400, 8'd255, 32'sd0);
		push_cmd(FN_QUERY, 3'd0, 11'd0, 11'sd0, 8'd0, 32'sd0);
		push_cmd(FN_QUERY_NEXT, 3'd0, 11'd0, 11'sd0, 8'd0, 32'h7FFF_FFFF);
		push_cmd(FN_INSERT, 3'd7, 11'd1439, 11'h3FF, 8'd0, 32'sd0);
		push_cmd(FN_INSERT, 3'd1, 11'd0, 11'h7FF, 8'd1, 32'sd0);
		push_cmd(FN_INSERT, 3'd3, 11'd600, 11'sd0, 8'd2, 32'sd0);
		push_cmd(FN_INSERT, 3'd3, 11'd600, 11'sd0, 8'd3, 32'sd0);
		push_cmd(FN_INSERT, 3'd2, 11'd700, -11'sd100, 8'd4, 32'sd0);
		push_cmd(FN_QUERY, 3'd0, 11'd0, 11'sd0, 8'd0, 32'h8000_0000);
		push_cmd(FN_QUERY_NEXT, 3'd0, 11'd0, 11'sd0, 8'd0, 32'h8000_0000);
		push_cmd(FN_QUERY, 3'd0, 11'd0, 11'sd0, 8'd0, 32'h7FFF_FFFF);
		push_cmd(FN_QUERY_NEXT, 3'd0, 11'd0, 11'sd0, 8'd0, 32'sd0);
		push_cmd(FN_QUERY, 3'd0, 11'd0, 11'sd0, 8'd0, 32'hFFFF_FFFF);
		push_cmd(FN_REMOVE, 3'd0, 11'd1500, 11'sd0, 8'd255, 32'sd0);
		push_cmd(FN_REMOVE, 3'd3, 11'd600, 11'sd0, 8'd9, 32'sd0);
		push_cmd(FN_REMOVE, 3'd3, 11'd600, 11'sd0, 8'd2, 32'sd0);
		push_cmd(FN_QUERY_NEXT, 3'd0, 11'd0, 11'sd0, 8'd0, 32'sd345600);
		push_cmd(FN_QUERY, 3'd0, 11'd0, 11'sd0, 8'd0, 32'sd518399);

		for (int p = 0; p < PHASES; p++) begin
			tzv = (p < 4) ? tz_plan[p] : 17'($urandom);
			epv = (p < 4) ? ep_plan[p] : 3'($urandom_range(0, 7));
			push_job(JOB_REG, REG_TIMEZONE, tzv, 0);
			push_job(JOB_REG, REG_EPOCH_DAY, {14'($urandom), epv}, 0);
			push_job(JOB_PACE, REG_TIMEZONE, '0, pace_plan[p % 4]);
			for (int k = 0; k < PHASE_CMDS; k++)
				add_random_cmd();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (backlog.size() != 0 || start)
			@(posedge clk);
		while (predicted_replies.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (faults == 0)
			$display("[weekly_event_schedule_table] OK");
		else
			$display("[weekly_event_schedule_table] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wes_pkg.sv
hw/rtl/weekly_event_schedule_table.sv
bench/tb_top.sv
